// ===== src/sm4fr_pkg.sv =====
// Package for the SM4 four-round unit: S-box table, round functions, stage type.
`timescale 1ns / 1ps

package sm4fr_pkg;

  // Operation codes
  localparam logic OP_CIPHER  = 1'b0;
  localparam logic OP_KEY_EXP = 1'b1;

  localparam int unsigned NUM_ROUNDS = 4;
  localparam int unsigned NUM_WORDS  = 8;

  // Per-stage payload: the word window grows by one word per round
  typedef struct packed {
    logic                              op;
    logic [NUM_WORDS-1:0][31:0]        words;
    logic [NUM_ROUNDS-1:0][31:0]       keys;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
    8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
    8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
    8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95,
    8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
    8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8,
    8'h68, 8'h6B, 8'h81, 8'hB2, 8'h71, 8'h64, 8'hDA, 8'h8B,
    8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2,
    8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
    8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
    8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
    8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
    8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
    8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
    8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
    8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
    8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
    8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
    8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
    8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
  };

  // Byte-wise S-box substitution of a word
  function automatic logic [31:0] sbox_word(input logic [31:0] v);
    logic [31:0] r;
    r = '0;
    for (int b = 0; b < 4; b++) begin
      r[8*b +: 8] = SBOX[v[8*b +: 8]];
    end
    return r;
  endfunction

  // Cipher linear mix L
  function automatic logic [31:0] mix_cipher(input logic [31:0] v);
    return v ^ {v[29:0], v[31:30]} ^ {v[21:0], v[31:22]}
             ^ {v[13:0], v[31:14]} ^ {v[7:0], v[31:8]};
  endfunction

  // Key-expansion linear mix L'
  function automatic logic [31:0] mix_key(input logic [31:0] v);
    return v ^ {v[18:0], v[31:19]} ^ {v[8:0], v[31:9]};
  endfunction

  // One SM4 round: new word from the four newest words and a key
  function automatic logic [31:0] one_round(input logic op, input logic [31:0] w0,
                                            input logic [31:0] w1, input logic [31:0] w2,
                                            input logic [31:0] w3, input logic [31:0] k);
    logic [31:0] s;
    s = sbox_word(w1 ^ w2 ^ w3 ^ k);
    return w0 ^ ((op == OP_KEY_EXP) ? mix_key(s) : mix_cipher(s));
  endfunction

endpackage

// ===== src/sm4fr_if.sv =====
// Valid/ready channel interfaces for the SM4 four-round unit.
`timescale 1ns / 1ps

interface sm4fr_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] state_word0;
  logic [31:0] state_word1;
  logic [31:0] state_word2;
  logic [31:0] state_word3;
  logic [31:0] round_key0;
  logic [31:0] round_key1;
  logic [31:0] round_key2;
  logic [31:0] round_key3;

  modport source (output valid, operation, state_word0, state_word1, state_word2,
                  state_word3, round_key0, round_key1, round_key2, round_key3,
                  input ready);
  modport sink (input valid, operation, state_word0, state_word1, state_word2,
                state_word3, round_key0, round_key1, round_key2, round_key3,
                output ready);
endinterface

interface sm4fr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word0;
  logic [31:0] out_word1;
  logic [31:0] out_word2;
  logic [31:0] out_word3;

  modport source (output valid, out_word0, out_word1, out_word2, out_word3,
                  input ready);
  modport sink (input valid, out_word0, out_word1, out_word2, out_word3,
                output ready);
endinterface

// ===== src/sm4_four_round_unit_core.sv =====
// SM4 four-round unit: top level, four-stage round pipeline.
`timescale 1ns / 1ps

// Runs four chained SM4 rounds (cipher or key-expansion mix) on one 128-bit
// lane per transfer. One round is computed per pipeline stage. The first stage
// loads at the input transfer edge, and the fourth stage offers the result.
// A new input can be taken every cycle while no stall reaches the first
// stage. Each stage has its own valid bit and only holds when the stage after
// it is full and stalled, so bubbles are squeezed out and a stall on the
// result side backs up the pipeline without losing or repeating a transfer.
// Results come out in input order, one per input.
module sm4_four_round_unit_core (
  input  logic               clk,
  input  logic               rst_n,
  sm4fr_in_if.sink           in_chan,
  sm4fr_out_if.source        out_chan
);

  localparam int unsigned NST = sm4fr_pkg::NUM_ROUNDS;

  sm4fr_pkg::stage_t      st_r   [NST];
  sm4fr_pkg::stage_t      st_nxt [NST];
  logic [NST-1:0]         vld_r;
  logic [NST-1:0]         vld_nxt;
  logic [NST:0]           adv;
  sm4fr_pkg::stage_t      in_stage;

  // Input payload packed into the stage layout
  always_comb begin
    in_stage          = '0;
    in_stage.op       = in_chan.operation;
    in_stage.words[0] = in_chan.state_word0;
    in_stage.words[1] = in_chan.state_word1;
    in_stage.words[2] = in_chan.state_word2;
    in_stage.words[3] = in_chan.state_word3;
    in_stage.keys[0]  = in_chan.round_key0;
    in_stage.keys[1]  = in_chan.round_key1;
    in_stage.keys[2]  = in_chan.round_key2;
    in_stage.keys[3]  = in_chan.round_key3;
  end

  // Stage advance: a stage loads when empty or when its contents move on
  always_comb begin
    adv[NST] = out_chan.ready;
    for (int i = NST - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  // Round logic: stage i computes round i from the previous stage
  always_comb begin
    sm4fr_pkg::stage_t src;
    for (int i = 0; i < NST; i++) begin
      src = (i == 0) ? in_stage : st_r[(i == 0) ? 0 : i - 1];
      st_nxt[i] = src;
      st_nxt[i].words[4+i] = sm4fr_pkg::one_round(src.op, src.words[i], src.words[i+1],
                                                  src.words[i+2], src.words[i+3],
                                                  src.keys[i]);
      vld_nxt[i] = (i == 0) ? in_chan.valid : vld_r[(i == 0) ? 0 : i - 1];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_nxt[i];
        end
      end
    end
  end

  // Stage payload, no reset needed
  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (adv[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  // Channel outputs
  assign in_chan.ready      = adv[0];
  assign out_chan.valid     = vld_r[NST-1];
  assign out_chan.out_word0 = st_r[NST-1].words[4];
  assign out_chan.out_word1 = st_r[NST-1].words[5];
  assign out_chan.out_word2 = st_r[NST-1].words[6];
  assign out_chan.out_word3 = st_r[NST-1].words[7];

  // Assertions
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> vld_r == '0)
    else $error("pipeline not empty after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NST-1] |-> in_chan.ready)
    else $error("input stalled while the last stage is empty");

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> vld_r[0])
    else $error("input transfer lost at the first stage");

  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] && !adv[2] |=> vld_r[1] && $stable(st_r[1].words))
    else $error("stalled middle stage changed");

endmodule

// ===== verif/sm4_four_round_unit_core_tb.sv =====
// Self-checking testbench for the SM4 four-round unit: random lanes, stalls, result scoreboard.
`timescale 1ns / 1ps

module sm4_four_round_unit_core_tb;

  localparam int unsigned RANDOM_ITEMS = 1930;
  localparam int unsigned QUIET_ITEMS  = 300;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam time         TIMEOUT_NS   = 2_000_000;

  // Lane as offered to the block, and the four words it gives back
  typedef struct packed {
    logic             op;
    logic [3:0][31:0] words;
    logic [3:0][31:0] keys;
  } lane_in_t;
  typedef logic [3:0][31:0] lane_out_t;

  // Independent copy of the SM4 substitution table
  localparam logic [7:0] SUBST [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7, 8'h16, 8'hB6, 8'h14, 8'hC2,
    8'h28, 8'hFB, 8'h2C, 8'h05, 8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9C, 8'h42, 8'h50, 8'hF4,
    8'h91, 8'hEF, 8'h98, 8'h7A, 8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95, 8'h80, 8'hDF, 8'h94, 8'hFA,
    8'h75, 8'h8F, 8'h3F, 8'hA6, 8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8, 8'h68, 8'h6B, 8'h81, 8'hB2,
    8'h71, 8'h64, 8'hDA, 8'h8B, 8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2, 8'h25, 8'h22, 8'h7C, 8'h3B,
    8'h01, 8'h21, 8'h78, 8'h87, 8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E, 8'hEA, 8'hBF, 8'h8A, 8'hD2,
    8'h40, 8'hC7, 8'h38, 8'hB5, 8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55, 8'hAD, 8'h93, 8'h32, 8'h30,
    8'hF5, 8'h8C, 8'hB1, 8'hE3, 8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F, 8'hD5, 8'hDB, 8'h37, 8'h45,
    8'hDE, 8'hFD, 8'h8E, 8'h2F, 8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F, 8'h11, 8'hD9, 8'h5C, 8'h41,
    8'h1F, 8'h10, 8'h5A, 8'hD8, 8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0, 8'h89, 8'h69, 8'h97, 8'h4A,
    8'h0C, 8'h96, 8'h77, 8'h7E, 8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20, 8'h79, 8'hEE, 8'h5F, 8'h3E,
    8'hD7, 8'hCB, 8'h39, 8'h48
  };

  // Predicts each lane's four round words and checks them in order
  class sm4_lane_scoreboard;
    lane_out_t   expected_q[$];
    int unsigned mismatch_cnt;
    int unsigned checked_cnt;

    function new();
      mismatch_cnt = 0;
      checked_cnt  = 0;
    endfunction

    static function logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
      return (v << n) | (v >> (32 - n));
    endfunction

    // One round: substitute x1^x2^x3^k bytewise, mix, fold into x0
    static function logic [31:0] round_word(input logic op, input logic [31:0] x0,
                                            input logic [31:0] x1, input logic [31:0] x2,
                                            input logic [31:0] x3, input logic [31:0] k);
      logic [31:0] t;
      logic [31:0] s;
      logic [31:0] mixed;
      t = x1 ^ x2 ^ x3 ^ k;
      for (int b = 0; b < 4; b++) s[8*b +: 8] = SUBST[t[8*b +: 8]];
      if (op == sm4fr_pkg::OP_KEY_EXP) mixed = s ^ rotl(s, 13) ^ rotl(s, 23);
      else mixed = s ^ rotl(s, 2) ^ rotl(s, 10) ^ rotl(s, 18) ^ rotl(s, 24);
      return x0 ^ mixed;
    endfunction

    static function lane_out_t lane_rounds(input lane_in_t it);
      logic [7:0][31:0] w;
      lane_out_t        res;
      for (int i = 0; i < 4; i++) w[i] = it.words[i];
      for (int r = 0; r < 4; r++) begin
        w[r+4] = round_word(it.op, w[r], w[r+1], w[r+2], w[r+3], it.keys[r]);
        res[r] = w[r+4];
      end
      return res;
    endfunction

    function void flag(input string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    function void note_input(input lane_in_t it);
      expected_q.push_back(lane_rounds(it));
    endfunction

    function void check_result(input lane_out_t got);
      lane_out_t exp_words;
      bit        bad;
      checked_cnt++;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result %h %h %h %h", got[0], got[1], got[2], got[3]));
        return;
      end
      exp_words = expected_q.pop_front();
      bad = 1'b0;
      for (int i = 0; i < 4; i++) if (got[i] !== exp_words[i]) bad = 1'b1;
      if (bad)
        flag($sformatf("result %0d exp %h %h %h %h act %h %h %h %h", checked_cnt,
                       exp_words[0], exp_words[1], exp_words[2], exp_words[3],
                       got[0], got[1], got[2], got[3]));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   quiet_phase = 1'b0;
  bit   hold_done   = 1'b0;

  sm4_lane_scoreboard sb;

  sm4fr_in_if  in_if ();
  sm4fr_out_if out_if ();

  sm4_four_round_unit_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #5 clk = ~clk;

  // Put a lane on the input channel payload
  task automatic drive_lane(input lane_in_t it);
    in_if.operation   = it.op;
    in_if.state_word0 = it.words[0];
    in_if.state_word1 = it.words[1];
    in_if.state_word2 = it.words[2];
    in_if.state_word3 = it.words[3];
    in_if.round_key0  = it.keys[0];
    in_if.round_key1  = it.keys[1];
    in_if.round_key2  = it.keys[2];
    in_if.round_key3  = it.keys[3];
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_lane(input lane_in_t it, input bit allow_idle);
    int unsigned gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    drive_lane(it);
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // Word mix with extra weight on all-zero, all-one, single-bit and repeated-byte patterns
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return {4{8'($urandom_range(0, 255))}};
      default: return $urandom;
    endcase
  endfunction

  function automatic lane_in_t rand_lane();
    lane_in_t it;
    it.op = $urandom_range(0, 1) ? sm4fr_pkg::OP_KEY_EXP : sm4fr_pkg::OP_CIPHER;
    for (int i = 0; i < 4; i++) begin
      it.words[i] = rand_word();
      it.keys[i]  = rand_word();
    end
    return it;
  endfunction

  // Fixed corner lanes, each run in both modes
  function automatic lane_in_t directed_lane(input int unsigned idx);
    lane_in_t it;
    it.op = (idx >= 10) ? sm4fr_pkg::OP_KEY_EXP : sm4fr_pkg::OP_CIPHER;
    case (idx % 10)
      0: begin it.words = '0; it.keys = '0; end
      1: begin it.words = '1; it.keys = '1; end
      2: begin
        // standard plaintext with the first four standard round keys
        it.words = {32'h76543210, 32'hfedcba98, 32'h89abcdef, 32'h01234567};
        it.keys  = {32'h7ba92077, 32'h5a6ab19a, 32'h41662b61, 32'hf12186f9};
      end
      3: begin
        // standard key xored with FK, first four CK constants
        it.words = {32'h76543210 ^ 32'hb27022dc, 32'hfedcba98 ^ 32'h677d9197,
                    32'h89abcdef ^ 32'h56aa3350, 32'h01234567 ^ 32'ha3b1bac6};
        it.keys  = {32'h545b6269, 32'h383f464d, 32'h1c232a31, 32'h00070e15};
      end
      4: begin it.words = {4{32'hAAAAAAAA}}; it.keys = {4{32'h55555555}}; end
      5: begin it.words = {4{32'h55555555}}; it.keys = {4{32'hAAAAAAAA}}; end
      6: begin it.words = {4{32'h80000000}}; it.keys = {4{32'h00000001}}; end
      7: begin
        it.words = {32'h00FF00FF, 32'hFF00FF00, 32'h0F0F0F0F, 32'hF0F0F0F0};
        it.keys  = {32'hFFFF0000, 32'h0000FFFF, 32'h00000000, 32'hFFFFFFFF};
      end
      8: begin it.words = '0; it.keys = {4{32'hFFFFFFFF}}; end
      default: begin it.words = {96'h0, 32'hFFFFFFFF}; it.keys = '0; end
    endcase
    return it;
  endfunction

  // Monitor: note input transfers and check result transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_input('{op: in_if.operation,
                        words: {in_if.state_word3, in_if.state_word2,
                                in_if.state_word1, in_if.state_word0},
                        keys: {in_if.round_key3, in_if.round_key2,
                               in_if.round_key1, in_if.round_key0}});
      if (out_if.valid && out_if.ready)
        sb.check_result({out_if.out_word3, out_if.out_word2,
                         out_if.out_word1, out_if.out_word0});
    end
  end

  // Result side: random stall bursts, one long hold-off to fill the pipeline
  initial begin
    int unsigned burst;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!hold_done && sb.checked_cnt >= HOLD_AFTER) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 6);
        out_if.ready = 1'b0;
        repeat (burst) @(negedge clk);
      end else begin
        out_if.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    lane_in_t item;
    sb = new();
    in_if.valid = 1'b0;
    drive_lane('0);
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    for (int unsigned i = 0; i < 20; i++) send_lane(directed_lane(i), 1'b1);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_phase = (n >= RANDOM_ITEMS - QUIET_ITEMS);
      item = rand_lane();
      send_lane(item, !quiet_phase);
    end
    in_if.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatch_cnt == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
